// ===== rtl/tec_pkg.sv =====
// types and constants shared by the touch event classifier
// no dependencies
package tec_pkg;

   localparam int PACKET_BYTES = 7;
   localparam int PACKET_W     = 8 * PACKET_BYTES;
   localparam int TIME_W       = 32;
   localparam int TIMEOUT_W    = 16;
   localparam int POS_W        = 12;
   localparam int CSR_IDX_W    = 1;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_FAIL   = 2'd1;
   localparam logic [1:0] MODE_PACKET = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_MOVE  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [1:0] FLAG_PRESS   = 2'b00;
   localparam logic [1:0] FLAG_LIFT    = 2'b01;
   localparam logic [1:0] FLAG_CONTACT = 2'b10;

   localparam logic [CSR_IDX_W-1:0] CSR_STALE_TIMEOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_TIMEOUT = 1'd1;

   localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = 16'd50;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] now_ms;
      logic [7:0]        pkt_byte0;
      logic [7:0]        pkt_gesture;
      logic [7:0]        pkt_points;
      logic [7:0]        pkt_xhigh_flag;
      logic [7:0]        pkt_xlow;
      logic [7:0]        pkt_yhigh;
      logic [7:0]        pkt_ylow;
   } req_type;

   typedef struct packed {
      logic [1:0]       event_kind;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } rsp_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] stale_timeout;
      logic [TIMEOUT_W-1:0] missing_timeout;
   } timeouts_type;

endpackage

// ===== rtl/touch_event_classifier_top.sv =====
// a poll word is registered in the input register, decided combinationally
// and its event word is registered out in the output register (rsp_valid)
// throughput: one word per cycle while rsp_stall is low; the touch state is
// updated at the edge that moves a word from the input to the output register
// reset: synchronous, active high; clears the touch state and valids,
// timeouts return to 50 ms
module touch_event_classifier_top import tec_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0] csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_type      in_word_ff, in_word_in;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_word_ff, out_word_in;
   logic         advance;
   timeouts_type timeouts;
   rsp_type      result;

   tec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timeouts  (timeouts)
   );

   tec_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_word_ff),
      .timeouts (timeouts),
      .result   (result)
   );

   // the input word moves on when the output register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_word_in  = req_data;
      end
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

// ===== rtl/tec_csr.sv =====
// timeout registers written over the csr channel
// depends on tec_pkg
module tec_csr import tec_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0] csr_wdata,
   output timeouts_type         timeouts
);

   timeouts_type regs_ff, regs_in;

   assign csr_ready = 1'b1;
   assign timeouts  = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STALE_TIMEOUT:   regs_in.stale_timeout   = csr_wdata;
            CSR_MISSING_TIMEOUT: regs_in.missing_timeout = csr_wdata;
            default:             regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.stale_timeout   <= DEFAULT_TIMEOUT;
         regs_ff.missing_timeout <= DEFAULT_TIMEOUT;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== rtl/tec_core.sv =====
// touch state and combinational decision logic for one poll word
// depends on tec_pkg
module tec_core import tec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      item,
   input  timeouts_type timeouts,
   output rsp_type      result
);

   logic [PACKET_W-1:0] prev_packet_ff, prev_packet_in;
   logic [POS_W-1:0]    last_x_ff, last_x_in;
   logic [POS_W-1:0]    last_y_ff, last_y_in;
   logic [TIME_W-1:0]   last_poll_ff, last_poll_in;
   logic [TIME_W-1:0]   last_packet_ff, last_packet_in;
   logic                active_ff, active_in;

   logic [PACKET_W-1:0] packet;
   logic [TIME_W-1:0]   poll_age, packet_age;
   logic                stale_hit, missing_hit;
   logic [3:0]          points;
   logic [1:0]          flag;
   logic [1:0]          kind;
   logic                with_pos;

   assign packet = {item.pkt_ylow, item.pkt_yhigh, item.pkt_xlow, item.pkt_xhigh_flag,
                    item.pkt_points, item.pkt_gesture, item.pkt_byte0};

   // ages wrap modulo 2^32
   assign poll_age    = item.now_ms - last_poll_ff;
   assign packet_age  = item.now_ms - last_packet_ff;
   assign stale_hit   = poll_age >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeouts.stale_timeout};
   assign missing_hit = packet_age >= {{(TIME_W-TIMEOUT_W){1'b0}}, timeouts.missing_timeout};
   assign points      = item.pkt_points[3:0];
   assign flag        = item.pkt_xhigh_flag[7:6];

   always_comb begin
      prev_packet_in = prev_packet_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      last_poll_in   = item.now_ms;
      last_packet_in = last_packet_ff;
      active_in      = active_ff;
      kind           = KIND_NONE;
      with_pos       = 1'b0;
      priority if (item.mode == MODE_IDLE) begin
         if (active_ff && missing_hit) begin
            active_in = 1'b0;
            kind      = KIND_END;
            with_pos  = 1'b1;
         end
      end else if (!active_ff && stale_hit) begin
         kind = KIND_NONE;
      end else if (item.mode == MODE_PACKET) begin
         last_packet_in = item.now_ms;
         if (packet != prev_packet_ff) begin
            prev_packet_in = packet;
            if (item.pkt_gesture == 8'd0) begin
               last_x_in = {item.pkt_xhigh_flag[3:0], item.pkt_xlow};
               last_y_in = {item.pkt_yhigh[3:0], item.pkt_ylow};
               priority if (points == 4'd1 && flag == FLAG_PRESS) begin
                  active_in = 1'b1;
                  kind      = KIND_START;
                  with_pos  = 1'b1;
               end else if (points == 4'd1 && flag == FLAG_CONTACT) begin
                  kind     = KIND_MOVE;
                  with_pos = 1'b1;
               end else if (points == 4'd0 && flag == FLAG_LIFT) begin
                  active_in = 1'b0;
                  kind      = KIND_END;
                  with_pos  = 1'b1;
               end else begin
                  kind = KIND_NONE;
               end
            end
         end
      end else begin
         // read failure, mode 3 included
         kind = KIND_NONE;
      end
   end

   assign result.event_kind = kind;
   assign result.pos_x      = with_pos ? last_x_in : '0;
   assign result.pos_y      = with_pos ? last_y_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_packet_ff <= '0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         last_poll_ff   <= '0;
         last_packet_ff <= '0;
         active_ff      <= 1'b0;
      end else if (fire) begin
         prev_packet_ff <= prev_packet_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         last_poll_ff   <= last_poll_in;
         last_packet_ff <= last_packet_in;
         active_ff      <= active_in;
      end
   end

endmodule
